/* src/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants for the three-level priority queue with
// promotion.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ENQ   = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  localparam logic [1:0] LVL_HIGH = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] req_id;
    logic [1:0]  req_level;
  } item_t;

  typedef struct packed {
    logic        served_valid;
    logic [15:0] served_id;
    logic [1:0]  served_level;
    logic        promoted;
    logic        overflow;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

endpackage

/* src/pfp_fifo.sv */
// ----------------------------------------------------------------------------
// pfp_fifo
// One circular queue of ids: storage array, head index, occupancy count,
// registered read of the head entry.
// ----------------------------------------------------------------------------
module pfp_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        pop,
  input  logic [15:0] wdata,
  output logic [15:0] rdata,
  output logic        empty,
  output logic        full
);

  logic [15:0]              mem [pfp_pkg::QUEUE_DEPTH];
  logic [pfp_pkg::PTR_W-1:0] head;
  logic [pfp_pkg::CNT_W-1:0] count;
  logic [pfp_pkg::PTR_W:0]   sum;
  logic [pfp_pkg::PTR_W:0]   tail_wide;
  logic [pfp_pkg::PTR_W-1:0] tail;
  logic [pfp_pkg::PTR_W-1:0] head_inc;

  always_comb begin
    sum = (pfp_pkg::PTR_W + 1)'(head) + (pfp_pkg::PTR_W + 1)'(count);
    if (sum >= (pfp_pkg::PTR_W + 1)'(pfp_pkg::QUEUE_DEPTH)) begin
      tail_wide = sum - (pfp_pkg::PTR_W + 1)'(pfp_pkg::QUEUE_DEPTH);
    end else begin
      tail_wide = sum;
    end
    tail = tail_wide[pfp_pkg::PTR_W-1:0];
    if (head == pfp_pkg::PTR_W'(pfp_pkg::QUEUE_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head + pfp_pkg::PTR_W'(1);
    end
  end

  assign empty = (count == '0);
  assign full  = (count == pfp_pkg::CNT_W'(pfp_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wdata;
    end
    rdata <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head_inc;
      end
      if (push && !pop) begin
        count <= count + pfp_pkg::CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pfp_pkg::CNT_W'(1);
      end
    end
  end

endmodule

/* src/pfp_datapath.sv */
// ----------------------------------------------------------------------------
// pfp_datapath
// Item register, the three queues, serve/enqueue decision and the result
// register.
// ----------------------------------------------------------------------------
module pfp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  pfp_pkg::ctrl_cmd_t    ctrl,
  output pfp_pkg::ctrl_status_t status,
  input  pfp_pkg::item_t        item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output pfp_pkg::result_t      result
);

  pfp_pkg::item_t   cur;
  pfp_pkg::result_t res_next;

  logic        hi_push, hi_pop, hi_empty, hi_full;
  logic        md_push, md_pop, md_empty, md_full;
  logic        lo_push, lo_pop, lo_empty, lo_full;
  logic [15:0] hi_rdata, md_rdata, lo_rdata, hi_wdata;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur <= item;
    end
  end

  always_comb begin
    hi_push  = 1'b0;
    hi_pop   = 1'b0;
    md_push  = 1'b0;
    md_pop   = 1'b0;
    lo_push  = 1'b0;
    lo_pop   = 1'b0;
    hi_wdata = cur.req_id;
    res_next = '0;
    if (cur.cmd == pfp_pkg::CMD_ENQ) begin
      case (cur.req_level)
        pfp_pkg::LVL_HIGH: begin
          hi_push           = !hi_full;
          res_next.overflow = hi_full;
        end
        pfp_pkg::LVL_MID: begin
          md_push           = !md_full;
          res_next.overflow = md_full;
        end
        pfp_pkg::LVL_LOW: begin
          lo_push           = !lo_full;
          res_next.overflow = lo_full;
        end
        default: begin
        end
      endcase
    end else if (!hi_empty) begin
      hi_pop                = 1'b1;
      res_next.served_valid = 1'b1;
      res_next.served_id    = hi_rdata;
      res_next.served_level = pfp_pkg::LVL_HIGH;
      if (!md_empty) begin
        md_pop            = 1'b1;
        hi_push           = 1'b1;
        hi_wdata          = md_rdata;
        res_next.promoted = 1'b1;
      end
    end else if (!md_empty) begin
      md_pop                = 1'b1;
      res_next.served_valid = 1'b1;
      res_next.served_id    = md_rdata;
      res_next.served_level = pfp_pkg::LVL_MID;
    end else if (!lo_empty) begin
      lo_pop                = 1'b1;
      res_next.served_valid = 1'b1;
      res_next.served_id    = lo_rdata;
      res_next.served_level = pfp_pkg::LVL_LOW;
    end
  end

  pfp_fifo u_high (
    .clk   (clk),
    .rst   (rst),
    .push  (ctrl.commit && hi_push),
    .pop   (ctrl.commit && hi_pop),
    .wdata (hi_wdata),
    .rdata (hi_rdata),
    .empty (hi_empty),
    .full  (hi_full)
  );

  pfp_fifo u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (ctrl.commit && md_push),
    .pop   (ctrl.commit && md_pop),
    .wdata (cur.req_id),
    .rdata (md_rdata),
    .empty (md_empty),
    .full  (md_full)
  );

  pfp_fifo u_low (
    .clk   (clk),
    .rst   (rst),
    .push  (ctrl.commit && lo_push),
    .pop   (ctrl.commit && lo_pop),
    .wdata (cur.req_id),
    .rdata (lo_rdata),
    .empty (lo_empty),
    .full  (lo_full)
  );

  assign status.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      result <= res_next;
    end
  end

endmodule

/* src/pfp_ctrl.sv */
// ----------------------------------------------------------------------------
// pfp_ctrl
// Controller: takes one word, then commits it once the result register
// is free.
// ----------------------------------------------------------------------------
module pfp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  pfp_pkg::ctrl_status_t status,
  output pfp_pkg::ctrl_cmd_t    ctrl
);

  pfp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    item_ready  = 1'b0;
    ctrl        = '0;
    case (state)
      pfp_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctrl.load  = 1'b1;
          state_next = pfp_pkg::ST_EXEC;
        end
      end
      pfp_pkg::ST_EXEC: begin
        if (status.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = pfp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/three_level_priority_fifo_promote.sv */
// ----------------------------------------------------------------------------
// three_level_priority_fifo_promote
// Three strict-priority id queues (high, middle, low) with promotion of
// the middle head, if any, into high whenever high serves an id.
//
// Input channel item_valid/item_ready carries one word: cmd (enqueue or
// serve), req_id and req_level. Output channel result_valid/result_ready
// carries one result word per input word: served id and level, promoted
// and overflow flags.
// The result is registered at the commit, which follows acceptance once
// the output register is free; the registered head read of the queue
// memories settles while the word is loaded, the commit comes in ST_EXEC.
// One word is in flight at a time; the next word is taken while a result
// still waits in the output register.
// Reset: all three queues become empty and result_valid clears;
// no clearing pass is needed.
// Receiver stall: the commit of the word in flight waits until the
// output register is taken; input stalls behind it.
// ----------------------------------------------------------------------------
module three_level_priority_fifo_promote (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pfp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pfp_pkg::result_t result
);

  pfp_pkg::ctrl_cmd_t    ctrl;
  pfp_pkg::ctrl_status_t status;

  pfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .ctrl       (ctrl)
  );

  pfp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second word accepted while one is in flight");

  a_serve_no_ovf: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.served_valid |-> !result.overflow)
    else $error("overflow reported on a served word");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.served_valid |->
      result.served_id == 16'd0 && !result.promoted &&
      result.served_level == pfp_pkg::LVL_HIGH)
    else $error("empty result carries data");

  a_promote_high: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.promoted |->
      result.served_valid && result.served_level == pfp_pkg::LVL_HIGH)
    else $error("promotion without a high serve");

endmodule

/* verif/pfp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfp_checker
// Watches both channels of the three-level priority queue. Every accepted
// input word is run through a local copy of the three id queues to build
// the result it must produce; every accepted result word is compared field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pfp_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  pfp_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  pfp_pkg::result_t result,
  output int               fails,
  output int               pending
);

  logic [15:0]      high_ids[$];
  logic [15:0]      mid_ids[$];
  logic [15:0]      low_ids[$];
  pfp_pkg::result_t due_results[$];
  pfp_pkg::result_t want;

  function automatic pfp_pkg::result_t queue_outcome(input pfp_pkg::item_t w);
    pfp_pkg::result_t r;
    r = '0;
    if (w.cmd == pfp_pkg::CMD_ENQ) begin
      case (w.req_level)
        pfp_pkg::LVL_HIGH: begin
          if (high_ids.size() < pfp_pkg::QUEUE_DEPTH) high_ids.push_back(w.req_id);
          else r.overflow = 1'b1;
        end
        pfp_pkg::LVL_MID: begin
          if (mid_ids.size() < pfp_pkg::QUEUE_DEPTH) mid_ids.push_back(w.req_id);
          else r.overflow = 1'b1;
        end
        pfp_pkg::LVL_LOW: begin
          if (low_ids.size() < pfp_pkg::QUEUE_DEPTH) low_ids.push_back(w.req_id);
          else r.overflow = 1'b1;
        end
        default: ;
      endcase
    end else if (high_ids.size() != 0) begin
      r.served_valid = 1'b1;
      r.served_id    = high_ids.pop_front();
      r.served_level = pfp_pkg::LVL_HIGH;
      // age the middle head upward into the slot just freed
      if (mid_ids.size() != 0) begin
        high_ids.push_back(mid_ids.pop_front());
        r.promoted = 1'b1;
      end
    end else if (mid_ids.size() != 0) begin
      r.served_valid = 1'b1;
      r.served_id    = mid_ids.pop_front();
      r.served_level = pfp_pkg::LVL_MID;
    end else if (low_ids.size() != 0) begin
      r.served_valid = 1'b1;
      r.served_id    = low_ids.pop_front();
      r.served_level = pfp_pkg::LVL_LOW;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      high_ids.delete();
      mid_ids.delete();
      low_ids.delete();
      due_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with nothing outstanding: expected none, actual %h",
                   $time, result);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("served_valid", 16'(want.served_valid), 16'(result.served_valid));
          check_field("served_id", want.served_id, result.served_id);
          check_field("served_level", 16'(want.served_level), 16'(result.served_level));
          check_field("promoted", 16'(want.promoted), 16'(result.promoted));
          check_field("overflow", 16'(want.overflow), 16'(result.overflow));
        end
      end
      if (item_valid && item_ready) due_results.push_back(queue_outcome(item));
    end
    pending = due_results.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-level priority queue with promotion.
// A short directed sequence covers empty serves, the unused level, id
// extremes, promotion and serving from each level; random episodes of
// filling, draining and middle-heavy traffic follow, with bursty idling
// on both channels. Checking lives in pfp_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] LVL_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 550;
  localparam int         CALM_AFTER   = 480;
  localparam int         CYCLE_LIMIT  = 200000;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  pfp_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  pfp_pkg::result_t result;
  int               fails;
  int               pending;
  int               cycles       = 0;
  int               stall_left   = 0;
  bit               calm         = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  three_level_priority_fifo_promote u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  pfp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fails        (fails),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("three_level_priority_fifo_promote test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // hold the word until taken, then maybe drop valid for an idle burst
  task automatic send(input logic c, input logic [15:0] id, input logic [1:0] lvl);
    pfp_pkg::item_t w;
    w.cmd       = c;
    w.req_id    = id;
    w.req_level = lvl;
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  initial begin
    int          counted;
    int          mode;
    int          len;
    int          enq_pct;
    int          roll;
    logic        c;
    logic [1:0]  fav;
    logic [1:0]  lvl;
    logic [15:0] id;
    counted = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(pfp_pkg::CMD_SERVE, 16'($urandom), 2'($urandom_range(0, 3)));
    send(pfp_pkg::CMD_ENQ, 16'hFFFF, LVL_UNUSED);
    send(pfp_pkg::CMD_ENQ, 16'h0000, pfp_pkg::LVL_HIGH);
    send(pfp_pkg::CMD_ENQ, 16'hFFFF, pfp_pkg::LVL_HIGH);
    send(pfp_pkg::CMD_ENQ, 16'h1234, pfp_pkg::LVL_MID);
    send(pfp_pkg::CMD_ENQ, 16'hFFFF, pfp_pkg::LVL_MID);
    send(pfp_pkg::CMD_ENQ, 16'h0000, pfp_pkg::LVL_LOW);
    send(pfp_pkg::CMD_ENQ, 16'hFFFF, pfp_pkg::LVL_LOW);
    send(pfp_pkg::CMD_SERVE, 16'hFFFF, LVL_UNUSED);
    send(pfp_pkg::CMD_SERVE, 16'h0000, pfp_pkg::LVL_HIGH);
    send(pfp_pkg::CMD_SERVE, 16'($urandom), pfp_pkg::LVL_MID);
    send(pfp_pkg::CMD_SERVE, 16'($urandom), pfp_pkg::LVL_LOW);
    send(pfp_pkg::CMD_SERVE, 16'($urandom), pfp_pkg::LVL_HIGH);
    send(pfp_pkg::CMD_ENQ, 16'h00FF, pfp_pkg::LVL_MID);
    send(pfp_pkg::CMD_SERVE, 16'($urandom), pfp_pkg::LVL_MID);
    send(pfp_pkg::CMD_SERVE, 16'($urandom), pfp_pkg::LVL_HIGH);
    send(pfp_pkg::CMD_SERVE, 16'($urandom), LVL_UNUSED);

    while (counted < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 40);
      fav  = (mode == 3) ? pfp_pkg::LVL_MID : 2'($urandom_range(0, 2));
      case (mode)
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        2:       enq_pct = 50;
        default: enq_pct = 60;
      endcase
      for (int k = 0; k < len && counted < RANDOM_ITEMS; k++) begin
        c    = ($urandom_range(0, 99) < enq_pct) ? pfp_pkg::CMD_ENQ : pfp_pkg::CMD_SERVE;
        roll = $urandom_range(0, 15);
        if (roll == 0) lvl = LVL_UNUSED;
        else if (roll < 9) lvl = fav;
        else lvl = 2'($urandom_range(0, 2));
        roll = $urandom_range(0, 9);
        if (roll == 0) id = 16'h0000;
        else if (roll == 1) id = 16'hFFFF;
        else id = 16'($urandom);
        send(c, id, lvl);
        if (!(c == pfp_pkg::CMD_ENQ && lvl == LVL_UNUSED)) counted++;
        if (counted >= CALM_AFTER) calm = 1'b1;
      end
    end

    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("three_level_priority_fifo_promote test passed");
    end else begin
      $display("three_level_priority_fifo_promote test failed");
    end
    $finish;
  end

endmodule

/* three_level_priority_fifo_promote.f */
src/pfp_pkg.sv
src/pfp_fifo.sv
src/pfp_datapath.sv
src/pfp_ctrl.sv
src/three_level_priority_fifo_promote.sv
verif/pfp_checker.sv
verif/tb_top.sv
